// ===== hdl/c2ns_pkg.sv =====
package c2ns_pkg;

    localparam int unsigned CountW = 64;
    localparam int unsigned FreqW  = 32;
    localparam int unsigned Steps  = 64;
    localparam int unsigned NsW    = 30;

    localparam logic [FreqW-1:0] FreqAtReset  = 32'd62500000;
    localparam logic [NsW-1:0]   NsPerSecond  = 30'd1000000000;

    // one division step in flight
    typedef struct packed {
        logic              valid;
        logic [FreqW-1:0]  rem;
        logic [CountW-1:0] dq;
        logic [CountW-1:0] aux;
    } t_cell;

endpackage

// ===== hdl/c2ns_cell.sv =====
module c2ns_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [c2ns_pkg::FreqW-1:0]   i_freq,
    input  c2ns_pkg::t_cell              i_cell,
    output c2ns_pkg::t_cell              o_cell
);

    logic [c2ns_pkg::FreqW:0] s_trial;
    logic                     s_bit;
    c2ns_pkg::t_cell          n_cell;
    c2ns_pkg::t_cell          r_cell;

    // restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        s_trial = {i_cell.rem, i_cell.dq[c2ns_pkg::CountW-1]};
        s_bit   = (s_trial >= {1'b0, i_freq});
        n_cell  = i_cell;
        n_cell.dq = {i_cell.dq[c2ns_pkg::CountW-2:0], s_bit};
        if (s_bit) begin
            n_cell.rem = c2ns_pkg::FreqW'(s_trial - {1'b0, i_freq});
        end else begin
            n_cell.rem = s_trial[c2ns_pkg::FreqW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== hdl/c2ns_div.sv =====
module c2ns_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [c2ns_pkg::FreqW-1:0]   i_freq,
    input  c2ns_pkg::t_cell              i_cell,
    output c2ns_pkg::t_cell              o_cell
);

    c2ns_pkg::t_cell s_link [c2ns_pkg::Steps+1];

    assign s_link[0] = i_cell;

    // one quotient bit per cell, msb first
    for (genvar g = 0; g < c2ns_pkg::Steps; g++) begin : g_cell
        c2ns_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_freq  (i_freq),
            .i_cell  (s_link[g]),
            .o_cell  (s_link[g+1])
        );
    end

    assign o_cell = s_link[c2ns_pkg::Steps];

endmodule

// ===== hdl/counter_to_nanoseconds.sv =====
// Converts a 64-bit counter reading to nanoseconds at the rate in i_cfg_data (hertz, reset
// 62500000, zero gives result 0). Fully pipelined: one item per cycle unless the output stalls;
// it uses two chains of 64 restoring-division cells (one quotient bit per cell) plus the
// multiply stages. The whole pipe holds while a result waits and is not taken.
module counter_to_nanoseconds (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [c2ns_pkg::FreqW-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [c2ns_pkg::CountW-1:0]   s_axis_tdata,  // count_value[63:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [c2ns_pkg::CountW-1:0]   m_axis_tdata   // nanoseconds[63:0]
);

    logic [c2ns_pkg::FreqW-1:0] r_freq;
    logic                       s_en;
    c2ns_pkg::t_cell            s_in1;
    c2ns_pkg::t_cell            s_out1;
    c2ns_pkg::t_cell            s_in2;
    c2ns_pkg::t_cell            s_out2;

    logic                        r_m1_valid;
    logic [c2ns_pkg::CountW-1:0] r_m1_prod;
    logic [c2ns_pkg::CountW-1:0] r_m1_whole;

    logic                        r_m2_valid;
    logic [c2ns_pkg::CountW-1:0] r_m2_lo;
    logic [31:0]                 r_m2_hi;
    logic [c2ns_pkg::NsW-1:0]    r_m2_sub;

    logic                        r_o_valid;
    logic [c2ns_pkg::CountW-1:0] r_o_data;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= c2ns_pkg::FreqAtReset;
        end else if (i_cfg_we) begin
            r_freq <= i_cfg_data;
        end
    end

    // global advance
    assign s_en          = !r_o_valid || m_axis_tready;
    assign s_axis_tready = s_en;

    // first division: count / freq
    always_comb begin
        s_in1.valid = s_axis_tvalid;
        s_in1.rem   = '0;
        s_in1.dq    = s_axis_tdata;
        s_in1.aux   = '0;
    end

    c2ns_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_freq  (r_freq),
        .i_cell  (s_in1),
        .o_cell  (s_out1)
    );

    // scale remainder by one billion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (s_en) begin
            r_m1_valid <= s_out1.valid;
            r_m1_prod  <= c2ns_pkg::CountW'(s_out1.rem)
                          * c2ns_pkg::CountW'(c2ns_pkg::NsPerSecond);
            r_m1_whole <= s_out1.dq;
        end
    end

    // second division: scaled remainder / freq, whole seconds ride along
    always_comb begin
        s_in2.valid = r_m1_valid;
        s_in2.rem   = '0;
        s_in2.dq    = r_m1_prod;
        s_in2.aux   = r_m1_whole;
    end

    c2ns_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_freq  (r_freq),
        .i_cell  (s_in2),
        .o_cell  (s_out2)
    );

    // seconds times one billion in two 32-bit halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (s_en) begin
            r_m2_valid <= s_out2.valid;
            r_m2_lo    <= c2ns_pkg::CountW'(s_out2.aux[31:0])
                          * c2ns_pkg::CountW'(c2ns_pkg::NsPerSecond);
            r_m2_hi    <= 32'(s_out2.aux[63:32] * c2ns_pkg::NsPerSecond);
            r_m2_sub   <= s_out2.dq[c2ns_pkg::NsW-1:0];
        end
    end

    // final sum, zero rate forces zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s_en) begin
            r_o_valid <= r_m2_valid;
            if (r_freq == '0) begin
                r_o_data <= '0;
            end else begin
                r_o_data <= r_m2_lo + {r_m2_hi, 32'd0}
                            + {{(c2ns_pkg::CountW-c2ns_pkg::NsW){1'b0}}, r_m2_sub};
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

`ifndef SYNTH
    // remainder of the first division stays below the rate
    a_rem_below_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out1.valid && r_freq != '0) |-> (s_out1.rem < r_freq))
        else $error("first remainder not below rate");

    // scaled remainder fits in 62 bits
    a_prod_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m1_valid |-> (r_m1_prod[63:62] == 2'b00))
        else $error("scaled remainder overflow");

    // sub-second part stays below one billion
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out2.valid && r_freq != '0) |-> (s_out2.dq < 64'd1000000000))
        else $error("sub-second part out of range");

    // stalled pipe keeps the waiting result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !m_axis_tready) |=> (r_o_valid && $stable(r_o_data)))
        else $error("result changed while stalled");
`endif

endmodule

// ===== sim/counter_to_nanoseconds_tb.sv =====
`timescale 1ns / 1ps

module counter_to_nanoseconds_tb;

    localparam int unsigned PipeLatency = 131;
    localparam int unsigned IdleLimit   = 20000;
    localparam int unsigned RandomItems = 1030;

    // conversion of one counter reading at a given rate
    function automatic logic [63:0] count_to_ns(logic [63:0] count, logic [31:0] hz);
        logic [63:0] whole;
        logic [63:0] part;
        logic [63:0] sub;
        if (hz == '0) begin
            return '0;
        end
        whole = count / {32'd0, hz};
        part  = count % {32'd0, hz};
        sub   = (part * 64'd1000000000) / {32'd0, hz};
        return whole * 64'd1000000000 + sub;
    endfunction

    // expected nanoseconds in order of acceptance
    class ns_scoreboard;
        logic [63:0] pending_ns[$];
        logic [31:0] rate_hz;
        int          n_errors;
        int          n_checked;

        function new();
            rate_hz   = c2ns_pkg::FreqAtReset;
            n_errors  = 0;
            n_checked = 0;
        endfunction

        function void note_count(logic [63:0] count);
            pending_ns.push_back(count_to_ns(count, rate_hz));
        endfunction

        function void check_ns(logic [63:0] got);
            logic [63:0] want;
            if (pending_ns.size() == 0) begin
                $error("nanoseconds: no item expected, actual %0d", got);
                n_errors++;
                return;
            end
            want = pending_ns.pop_front();
            n_checked++;
            if (want !== got) begin
                $error("nanoseconds: expected %0d actual %0d", want, got);
                n_errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    ns_scoreboard sb;
    bit           idle_on;
    bit           hold_off;
    int unsigned  quiet_cycles;
    int unsigned  n_sent;

    counter_to_nanoseconds i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // check results and count quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_ns(m_axis_tdata);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IdleLimit) begin
            $display("counter_to_nanoseconds verification failed");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (idle_on) begin
            m_axis_tready <= ($urandom_range(99) >= 29);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand_count();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = v >> $urandom_range(63);
            1: v = v & 64'hFFFF_FFFF;
            2: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // offer one count and wait for it to be taken
    task automatic send_count(logic [63:0] count);
        while (idle_on && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= count;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_count(count);
        n_sent++;
    endtask

    // stop offering items
    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    // drain, then write the rate while idle
    task automatic set_rate(logic [31:0] hz);
        stop_sending();
        while (sb.pending_ns.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= hz;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.rate_hz = hz;
    endtask

    task automatic directed_counts();
        send_count('0);
        send_count(64'd1);
        send_count('1);
        send_count(64'h8000_0000_0000_0000);
        send_count(64'hFFFF_FFFF);
        send_count(64'h1_0000_0000);
        send_count({32'd0, sb.rate_hz});
        send_count({32'd0, sb.rate_hz} - 1);
        send_count(64'hAAAA_AAAA_AAAA_AAAA);
        send_count(64'h5555_5555_5555_5555);
    endtask

    initial begin
        logic [31:0] rates[6];
        sb            = new();
        idle_on       = 1'b1;
        hold_off      = 1'b0;
        quiet_cycles  = 0;
        n_sent        = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        rates = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1000000000, 32'd19200000, 32'd62500000};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset rate, directed then zero rate and other extremes
        directed_counts();
        set_rate(rates[0]);
        directed_counts();
        set_rate(rates[2]);
        send_count('1);
        send_count(64'hFFFF_FFFE);

        // random phases across rates
        for (int p = 0; p < 6; p++) begin
            if (p == 1) begin
                set_rate(rates[1]);
            end else if (p > 1) begin
                set_rate((p == 4) ? $urandom : rates[p]);
            end
            if (p == 2) begin
                idle_on = 1'b0;
            end else begin
                idle_on = 1'b1;
            end
            if (p == 3) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < RandomItems / 6; k++) begin
                send_count(rand_count());
            end
        end

        stop_sending();
        while (sb.pending_ns.size() != 0) @(posedge i_clk);
        repeat (PipeLatency + 8) @(posedge i_clk);
        $display("sent %0d counts, checked %0d results over six rates", n_sent,
                 sb.n_checked);
        $display("rates included zero, one, all ones and random values");
        if (sb.n_errors == 0 && sb.pending_ns.size() == 0) begin
            $display("counter_to_nanoseconds verification clean");
        end else begin
            $display("counter_to_nanoseconds verification failed");
        end
        $finish;
    end

endmodule
